>>> sv/eocs_pkg.sv
// shared types and constants for the eight-op processor step core
// no dependencies; imported by every module of the block
package eocs_pkg;

  localparam int WORD_W    = 32;
  localparam int CFG_AW    = 3;
  localparam int RF_ADDR_W = 4;
  localparam int RF_DEPTH  = 16;
  localparam int IMM_W     = 20;
  localparam int START_W   = 12;

  localparam logic REG_START_PC = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_READ    = 2'd1,
    OP_STEP    = 2'd2,
    OP_RESTART = 2'd3
  } item_op_t;

  typedef enum logic [3:0] {
    OPC_ADD  = 4'd0,
    OPC_NAND = 4'd1,
    OPC_ADDI = 4'd2,
    OPC_LW   = 4'd3,
    OPC_SW   = 4'd4,
    OPC_BEQ  = 4'd5,
    OPC_JALR = 4'd6,
    OPC_HALT = 4'd7
  } opcode_t;

  typedef enum logic {
    ALU_ADD  = 1'b0,
    ALU_NAND = 1'b1
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AWAIT,
    S_MRD,
    S_EXEC,
    S_BRANCH,
    S_DWAIT,
    S_LWB,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        mem_addr;
    logic [WORD_W-1:0]  mem_data;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0]  read_word;
    logic [WORD_W-1:0]  pc_now;
    logic               is_halted;
    logic [3:0]         last_opcode;
  } out_t;

  typedef struct packed {
    logic                 re;
    logic [RF_ADDR_W-1:0] addr_a;
    logic [RF_ADDR_W-1:0] addr_b;
  } rf_rd_req_t;

  typedef struct packed {
    logic                 we;
    logic [RF_ADDR_W-1:0] addr;
    logic [WORD_W-1:0]    data;
  } rf_wr_req_t;

endpackage

>>> sv/eocs_alu.sv
// shared add / nand / equality unit used by the pc increment, execute and branch steps
// depends on eocs_pkg
module eocs_alu (
  input  eocs_pkg::alu_op_t           op,
  input  logic [eocs_pkg::WORD_W-1:0] a,
  input  logic [eocs_pkg::WORD_W-1:0] b,
  output logic [eocs_pkg::WORD_W-1:0] y,
  output logic                        eq
);
  import eocs_pkg::*;

  always_comb begin
    case (op)
      ALU_ADD:  y = a + b;
      ALU_NAND: y = ~(a & b);
      default:  y = a + b;
    endcase
  end

  assign eq = (a == b);

endmodule

>>> sv/eocs_wrap.sv
// reduces a 32-bit word address modulo the memory depth
// mask when the depth is a power of two, else a three-stage reciprocal multiply
// depends on eocs_pkg
module eocs_wrap #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [eocs_pkg::WORD_W-1:0]  value,
  output logic                         done,
  output logic [$clog2(MEM_WORDS)-1:0] result
);
  import eocs_pkg::*;

  localparam int  AW   = $clog2(MEM_WORDS);
  localparam bit  POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

  generate
    if (POW2) begin : g_mask
      logic          done_r;
      logic [AW-1:0] res_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          res_r <= value[AW-1:0];
        end
      end

      assign done   = done_r;
      assign result = res_r;
    end else begin : g_recip
      // quotient estimate from floor(2^32 / depth) is low by at most one
      localparam logic [WORD_W-1:0] RECIP = WORD_W'((64'd1 << WORD_W) / MEM_WORDS);
      localparam logic [WORD_W-1:0] MOD_W = WORD_W'(MEM_WORDS);

      logic [2:0]          stage_r;
      logic                done_r;
      logic [WORD_W-1:0]   val_r;
      logic [WORD_W-1:0]   quo_r;
      logic [WORD_W-1:0]   rem_r;
      logic [AW-1:0]       res_r;
      logic [2*WORD_W-1:0] prod;
      logic [WORD_W-1:0]   quo_mul;

      assign prod    = val_r * RECIP;
      assign quo_mul = quo_r * MOD_W;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stage_r <= '0;
          done_r  <= 1'b0;
        end else begin
          stage_r <= {stage_r[1:0], start};
          done_r  <= stage_r[2];
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          val_r <= value;
        end
        if (stage_r[0]) begin
          quo_r <= prod[2*WORD_W-1:WORD_W];
        end
        if (stage_r[1]) begin
          rem_r <= val_r - quo_mul;
        end
        if (stage_r[2]) begin
          res_r <= (rem_r >= MOD_W) ? AW'(rem_r - MOD_W) : AW'(rem_r);
        end
      end

      assign done   = done_r;
      assign result = res_r;
    end
  endgenerate

endmodule

>>> sv/eocs_regfile.sv
// sixteen 32-bit general registers, two registered read ports, one write port
// entries read as zero until first written after reset
// depends on eocs_pkg
module eocs_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  eocs_pkg::rf_rd_req_t        rd_req,
  input  eocs_pkg::rf_wr_req_t        wr_req,
  output logic [eocs_pkg::WORD_W-1:0] rdata_a,
  output logic [eocs_pkg::WORD_W-1:0] rdata_b
);
  import eocs_pkg::*;

  logic [WORD_W-1:0]   regs_r [RF_DEPTH];
  logic [RF_DEPTH-1:0] valid_r;
  logic [WORD_W-1:0]   rdata_a_r;
  logic [WORD_W-1:0]   rdata_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_req.we) begin
      valid_r[wr_req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req.we) begin
      regs_r[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.re) begin
      rdata_a_r <= valid_r[rd_req.addr_a] ? regs_r[rd_req.addr_a] : '0;
      rdata_b_r <= valid_r[rd_req.addr_b] ? regs_r[rd_req.addr_b] : '0;
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> sv/eight_op_cpu_step_core.sv
// top level of the eight-op processor step core: sequencer, word memory, config port
// depends on eocs_pkg, eocs_alu, eocs_wrap, eocs_regfile
//
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------------------
//  in      | in_valid / in_ready            | in_data   (op, mem_addr, mem_data)
//  out     | out_valid / out_ready          | out_data  (read_word, pc_now, ...)
//  cfg     | cfg_psel/penable/pwrite/pready | cfg_paddr, cfg_pwdata, cfg_prdata
//
// one beat at a time; in_ready is high only while the sequencer is idle
// states per beat: restart or a halted step take idle, done; load idle, await, done;
// read adds mrd; a step adds mrd, exec, plus branch on a taken beq, dwait on sw, dwait
// and lwb on lw; await and dwait wait for the wrap unit's reduction of the address
// the result register lets the next beat enter while a result waits for out_ready
// reset clears pc, halt, general registers and start_pc; memory keeps no reset
module eight_op_cpu_step_core #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  eocs_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output eocs_pkg::out_t               out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [eocs_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [eocs_pkg::WORD_W-1:0]  cfg_pwdata,
  output logic [eocs_pkg::WORD_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import eocs_pkg::*;

  localparam int ADDR_W = $clog2(MEM_WORDS);

  state_t             state_r, state_nxt;
  in_t                item_r, item_nxt;
  logic [WORD_W-1:0]  pc_r, pc_nxt;
  logic               halt_r, halt_nxt;
  logic [WORD_W-1:0]  rd_word_r, rd_word_nxt;
  logic [3:0]         last_op_r, last_op_nxt;
  logic [WORD_W-1:0]  inst_r, inst_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [START_W-1:0] start_pc_r;

  logic [WORD_W-1:0]  mem_r [MEM_WORDS];
  logic [WORD_W-1:0]  mem_rdata_r;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [WORD_W-1:0]  mem_wdata;

  logic               wrap_start, wrap_done;
  logic [WORD_W-1:0]  wrap_value;
  logic [ADDR_W-1:0]  wrap_result;

  rf_rd_req_t         rf_rd;
  rf_wr_req_t         rf_wr;
  logic [WORD_W-1:0]  rf_a, rf_b;

  alu_op_t            alu_op;
  logic [WORD_W-1:0]  alu_a, alu_b, alu_y;
  logic               alu_eq;

  opcode_t            opc, fopc;
  logic [WORD_W-1:0]  imm;
  logic               cfg_wr;

  eocs_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .eq (alu_eq)
  );

  eocs_wrap #(.MEM_WORDS(MEM_WORDS)) u_wrap (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wrap_start),
    .value  (wrap_value),
    .done   (wrap_done),
    .result (wrap_result)
  );

  eocs_regfile u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rf_rd),
    .wr_req  (rf_wr),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  // config port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_START_PC) ? WORD_W'(start_pc_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pc_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == REG_START_PC) begin
      start_pc_r <= cfg_pwdata[START_W-1:0];
    end
  end

  // word memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem_r[mem_addr];
    end
  end

  // instruction fields
  assign opc  = opcode_t'(inst_r[31:28]);
  assign fopc = opcode_t'(mem_rdata_r[31:28]);
  assign imm  = {{(WORD_W - IMM_W){inst_r[IMM_W-1]}}, inst_r[IMM_W-1:0]};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    pc_nxt        = pc_r;
    halt_nxt      = halt_r;
    rd_word_nxt   = rd_word_r;
    last_op_nxt   = last_op_r;
    inst_nxt      = inst_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wrap_start    = 1'b0;
    wrap_value    = pc_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = wrap_result;
    mem_wdata     = item_r.mem_data;
    rf_rd         = '0;
    rf_wr         = '0;
    alu_op        = ALU_ADD;
    alu_a         = pc_r;
    alu_b         = WORD_W'(1);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          rd_word_nxt = '0;
          last_op_nxt = '0;
          case (item_op_t'(in_data.op))
            OP_LOAD, OP_READ: begin
              wrap_start = 1'b1;
              wrap_value = WORD_W'(in_data.mem_addr);
              state_nxt  = S_AWAIT;
            end
            OP_STEP: begin
              if (halt_r) begin
                state_nxt = S_DONE;
              end else begin
                wrap_start = 1'b1;
                wrap_value = pc_r;
                state_nxt  = S_AWAIT;
              end
            end
            default: begin
              pc_nxt    = WORD_W'(start_pc_r);
              halt_nxt  = 1'b0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_AWAIT: begin
        if (wrap_done) begin
          if (item_op_t'(item_r.op) == OP_LOAD) begin
            mem_we    = 1'b1;
            state_nxt = S_DONE;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_MRD;
          end
        end
      end
      S_MRD: begin
        if (item_op_t'(item_r.op) == OP_READ) begin
          rd_word_nxt = mem_rdata_r;
          state_nxt   = S_DONE;
        end else begin
          // fetched word: bump pc, read operands
          inst_nxt     = mem_rdata_r;
          pc_nxt       = alu_y;
          last_op_nxt  = mem_rdata_r[31:28];
          rf_rd.re     = 1'b1;
          rf_rd.addr_a = mem_rdata_r[23:20];
          rf_rd.addr_b = (fopc inside {OPC_ADD, OPC_NAND}) ? mem_rdata_r[3:0]
                                                           : mem_rdata_r[27:24];
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        alu_a     = rf_a;
        alu_b     = rf_b;
        case (opc)
          OPC_ADD: begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = inst_r[27:24];
            rf_wr.data = alu_y;
          end
          OPC_NAND: begin
            alu_op     = ALU_NAND;
            rf_wr.we   = 1'b1;
            rf_wr.addr = inst_r[27:24];
            rf_wr.data = alu_y;
          end
          OPC_ADDI: begin
            alu_b      = imm;
            rf_wr.we   = 1'b1;
            rf_wr.addr = inst_r[27:24];
            rf_wr.data = alu_y;
          end
          OPC_LW, OPC_SW: begin
            alu_b      = imm;
            wrap_start = 1'b1;
            wrap_value = alu_y;
            state_nxt  = S_DWAIT;
          end
          OPC_BEQ: begin
            if (alu_eq) begin
              state_nxt = S_BRANCH;
            end
          end
          OPC_JALR: begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = inst_r[23:20];
            rf_wr.data = pc_r;
            pc_nxt     = rf_b;
          end
          OPC_HALT: begin
            halt_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_BRANCH: begin
        alu_b     = imm;
        pc_nxt    = alu_y;
        state_nxt = S_DONE;
      end
      S_DWAIT: begin
        if (wrap_done) begin
          if (opc == OPC_LW) begin
            mem_re    = 1'b1;
            state_nxt = S_LWB;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = rf_b;
            state_nxt = S_DONE;
          end
        end
      end
      S_LWB: begin
        rf_wr.we   = 1'b1;
        rf_wr.addr = inst_r[27:24];
        rf_wr.data = mem_rdata_r;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.read_word   = rd_word_r;
          out_nxt.pc_now      = pc_r;
          out_nxt.is_halted   = halt_r;
          out_nxt.last_opcode = last_op_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    rd_word_r <= rd_word_nxt;
    last_op_r <= last_op_nxt;
    inst_r    <= inst_nxt;
    out_r     <= out_nxt;
  end

`ifndef SYNTHESIS
  a_restart_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.op == OP_RESTART)
      |=> (pc_r == WORD_W'($past(start_pc_r)) && !halt_r))
    else $error("restart did not load start_pc or clear halt");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while a beat is in flight");

  a_halt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.op == OP_STEP && halt_r)
      |=> (pc_r == $past(pc_r) && halt_r))
    else $error("step while halted changed pc or halt");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
